// ----- sv/bve_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bve_pkg
// Types and constants shared by the bit vector engine modules.
// ---------------------------------------------------------------------------
package bve_pkg;

  localparam int MASK_BITS   = 256;
  localparam int CHUNK_BITS  = 32;
  localparam int NCHUNK      = MASK_BITS / CHUNK_BITS;
  localparam int CHUNK_IDX_W = $clog2(NCHUNK);
  localparam int BIT_POS_W   = $clog2(CHUNK_BITS);
  localparam int SHIFT_STEPS = $clog2(MASK_BITS);
  localparam int CNT_W       = 3;
  localparam int OP_W        = 4;
  localparam int FIELD_W     = 10;
  localparam int FSI_W       = 8;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [OP_W-1:0] OP_CLEAR_ALL = 4'd0;
  localparam logic [OP_W-1:0] OP_SET       = 4'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd2;
  localparam logic [OP_W-1:0] OP_TEST      = 4'd3;
  localparam logic [OP_W-1:0] OP_FIND      = 4'd4;
  localparam logic [OP_W-1:0] OP_AND       = 4'd5;
  localparam logic [OP_W-1:0] OP_OR        = 4'd6;
  localparam logic [OP_W-1:0] OP_SHIFT     = 4'd7;
  localparam logic [OP_W-1:0] OP_READ      = 4'd8;

  typedef logic [MASK_BITS-1:0]  vec_t;
  typedef logic [CHUNK_BITS-1:0] chunk_t;

  typedef enum logic [3:0] {
    K_CLEAR_ALL,
    K_SET,
    K_CLEAR,
    K_TEST,
    K_FIND,
    K_AND,
    K_OR,
    K_SHIFT,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic                   bit_ok;
    logic [CHUNK_IDX_W-1:0] bit_chunk;
    logic [BIT_POS_W-1:0]   bit_pos;
    logic [CHUNK_IDX_W-1:0] chunk_idx;
    chunk_t                 chunk_data;
    logic                   shift_up;
    logic [SHIFT_STEPS-1:0] shift_mag;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bk_status_t;

endpackage
`default_nettype wire

// ----- sv/bve_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bve_if
// Request and response channels of the bit vector engine.
// ---------------------------------------------------------------------------
interface bve_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic signed [9:0] bit_index;
  logic signed [9:0] shift_amount;
  logic [2:0]  chunk_index;
  logic [31:0] chunk_data;

  modport source (output valid, operation, bit_index, shift_amount, chunk_index, chunk_data,
                  input ready);
  modport sink (input valid, operation, bit_index, shift_amount, chunk_index, chunk_data,
                output ready);
endinterface

interface bve_rsp_if;
  logic        valid;
  logic        ready;
  logic        bit_is_set;
  logic        found_any;
  logic [7:0]  first_set_index;
  logic [31:0] chunk_value;

  modport source (output valid, bit_is_set, found_any, first_set_index, chunk_value,
                  input ready);
  modport sink (input valid, bit_is_set, found_any, first_set_index, chunk_value,
                output ready);
endinterface
`default_nettype wire

// ----- sv/bve_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bve_front
// Accepts requests and reduces each one to a command for the back end.
// ---------------------------------------------------------------------------
module bve_front
  import bve_pkg::*;
(
  bve_req_if.sink req_ch,
  output logic    cmd_valid,
  input  logic    cmd_ready,
  output cmd_t    cmd
);

  logic               bit_ok;
  logic [FIELD_W-1:0] mag;
  logic               far;

  assign cmd_valid    = req_ch.valid;
  assign req_ch.ready = cmd_ready;

  always_comb begin
    bit_ok = !req_ch.bit_index[FIELD_W-1] &&
             ({1'b0, req_ch.bit_index[FIELD_W-2:0]} < FIELD_W'(MASK_BITS));
    mag = req_ch.shift_amount[FIELD_W-1] ? FIELD_W'(-req_ch.shift_amount)
                                         : FIELD_W'(req_ch.shift_amount);
    far = (mag >= FIELD_W'(MASK_BITS));

    cmd.bit_ok     = bit_ok;
    cmd.bit_chunk  = req_ch.bit_index[BIT_POS_W +: CHUNK_IDX_W];
    cmd.bit_pos    = req_ch.bit_index[BIT_POS_W-1:0];
    cmd.chunk_idx  = req_ch.chunk_index;
    cmd.chunk_data = req_ch.chunk_data;
    cmd.shift_up   = !req_ch.shift_amount[FIELD_W-1];
    cmd.shift_mag  = mag[SHIFT_STEPS-1:0];

    case (req_ch.operation)
      OP_CLEAR_ALL: cmd.kind = K_CLEAR_ALL;
      OP_SET:       cmd.kind = bit_ok ? K_SET : K_NOP;
      OP_CLEAR:     cmd.kind = bit_ok ? K_CLEAR : K_NOP;
      OP_TEST:      cmd.kind = K_TEST;
      OP_FIND:      cmd.kind = K_FIND;
      OP_AND:       cmd.kind = K_AND;
      OP_OR:        cmd.kind = K_OR;
      OP_SHIFT: begin
        // A shift by the vector length or more empties it; a zero shift does nothing.
        if (far) begin
          cmd.kind = K_CLEAR_ALL;
        end else if (mag == '0) begin
          cmd.kind = K_NOP;
        end else begin
          cmd.kind = K_SHIFT;
        end
      end
      OP_READ:      cmd.kind = K_READ;
      default:      cmd.kind = K_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/bve_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bve_queue
// Two-entry command queue between the front end and the back end.
// ---------------------------------------------------------------------------
module bve_queue
  import bve_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- sv/bve_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bve_back
// Holds the bit vector and carries out commands; find and shift step over
// several cycles.
// ---------------------------------------------------------------------------
module bve_back
  import bve_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  cmd_t       cmd,
  bve_rsp_if.source  rsp_ch,
  output bk_status_t status
);

  bk_state_t              state, state_next;
  vec_t                   store, store_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic                   shift_up;
  logic [SHIFT_STEPS-1:0] shift_mag;
  logic                   out_valid, out_valid_next;
  logic                   res_bit, res_bit_next;
  logic                   res_found, res_found_next;
  logic [FSI_W-1:0]       res_fsi, res_fsi_next;
  chunk_t                 res_chunk, res_chunk_next;
  logic                   load;
  logic                   out_free;
  logic [CHUNK_IDX_W-1:0] rd_idx;
  chunk_t                 rd_chunk;
  logic [BIT_POS_W-1:0]   low_pos;

  function automatic logic [BIT_POS_W-1:0] lowest_set(input chunk_t c);
    logic [BIT_POS_W-1:0] p;
    p = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      if (c[i]) begin
        p = BIT_POS_W'(i);
      end
    end
    return p;
  endfunction

  // One step of the logarithmic shifter: distance is two to the power of step.
  function automatic vec_t shift_step(input vec_t v, input logic up,
                                      input logic [CNT_W-1:0] step);
    vec_t r;
    r = v;
    for (int k = 0; k < SHIFT_STEPS; k++) begin
      if (step == CNT_W'(k)) begin
        r = up ? (v << (1 << k)) : (v >> (1 << k));
      end
    end
    return r;
  endfunction

  assign out_free = !out_valid || rsp_ch.ready;

  always_comb begin
    if (state == BK_SCAN) begin
      rd_idx = cnt;
    end else if (cmd.kind == K_TEST) begin
      rd_idx = cmd.bit_chunk;
    end else begin
      rd_idx = cmd.chunk_idx;
    end
    rd_chunk = store[{rd_idx, {BIT_POS_W{1'b0}}} +: CHUNK_BITS];
    low_pos  = lowest_set(rd_chunk);
  end

  always_comb begin
    state_next     = state;
    store_next     = store;
    cnt_next       = cnt;
    cmd_pop        = 1'b0;
    load           = 1'b0;
    res_bit_next   = 1'b0;
    res_found_next = 1'b0;
    res_fsi_next   = '0;
    res_chunk_next = '0;

    case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            K_CLEAR_ALL: begin
              store_next = '0;
              load       = 1'b1;
            end
            K_SET: begin
              store_next[{cmd.bit_chunk, cmd.bit_pos}] = 1'b1;
              load = 1'b1;
            end
            K_CLEAR: begin
              store_next[{cmd.bit_chunk, cmd.bit_pos}] = 1'b0;
              load = 1'b1;
            end
            K_TEST: begin
              res_bit_next = cmd.bit_ok && rd_chunk[cmd.bit_pos];
              load         = 1'b1;
            end
            K_FIND: begin
              cnt_next   = '0;
              state_next = BK_SCAN;
            end
            K_AND: begin
              store_next[{cmd.chunk_idx, {BIT_POS_W{1'b0}}} +: CHUNK_BITS] =
                rd_chunk & cmd.chunk_data;
              load = 1'b1;
            end
            K_OR: begin
              store_next[{cmd.chunk_idx, {BIT_POS_W{1'b0}}} +: CHUNK_BITS] =
                rd_chunk | cmd.chunk_data;
              load = 1'b1;
            end
            K_SHIFT: begin
              cnt_next   = '0;
              state_next = BK_SHIFT;
            end
            K_READ: begin
              res_chunk_next = rd_chunk;
              load           = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (rd_chunk != '0) begin
          res_found_next = 1'b1;
          res_fsi_next   = FSI_W'({cnt, low_pos});
          load           = 1'b1;
          state_next     = BK_IDLE;
        end else if (cnt == CNT_W'(NCHUNK - 1)) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      BK_SHIFT: begin
        if (shift_mag[cnt]) begin
          store_next = shift_step(store, shift_up, cnt);
        end
        if (cnt == CNT_W'(SHIFT_STEPS - 1)) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    out_valid_next = load || (out_valid && !rsp_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      store     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      store     <= store_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      shift_up  <= cmd.shift_up;
      shift_mag <= cmd.shift_mag;
    end
    if (load) begin
      res_bit   <= res_bit_next;
      res_found <= res_found_next;
      res_fsi   <= res_fsi_next;
      res_chunk <= res_chunk_next;
    end
  end

  assign rsp_ch.valid           = out_valid;
  assign rsp_ch.bit_is_set      = res_bit;
  assign rsp_ch.found_any       = res_found;
  assign rsp_ch.first_set_index = res_fsi;
  assign rsp_ch.chunk_value     = res_chunk;

  assign status.busy = (state != BK_IDLE);
  assign status.pop  = cmd_pop;

endmodule
`default_nettype wire

// ----- sv/bit_vector_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Set, clear, test, and, or, read, clear all: queued, then registered as a response.
// Find first: one stored chunk examined per cycle until a set bit shows up or none is left.
// Shift: eight steps of a logarithmic shifter over the whole vector.
// One simple request per cycle while responses are taken; find and shift hold the back end.
// A two-entry queue lets requests arrive while the back end is busy or stalled.
// Synchronous reset clears the vector, the queue and the response valid flag.
// ---------------------------------------------------------------------------
// bit_vector_engine
// Bit vector with single-bit access, chunk logic, shift and find first set.
// ---------------------------------------------------------------------------
module bit_vector_engine
  import bve_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bve_req_if.sink   req_ch,
  bve_rsp_if.source rsp_ch
);

  logic       f_valid;
  logic       f_ready;
  cmd_t       f_cmd;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;
  bk_status_t bk_st;

  bve_front u_front (
    .req_ch    (req_ch),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bve_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  bve_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .rsp_ch    (rsp_ch),
    .status    (bk_st)
  );

`ifndef SYNTHESIS
  // No response may appear while a multi-cycle request is still in progress.
  a_busy_no_rsp: assert property (@(posedge clk) disable iff (rst)
    bk_st.busy |-> !rsp_ch.valid)
    else $error("response valid while back end busy");

  a_busy_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(bk_st.busy) |-> $past(bk_st.pop))
    else $error("back end became busy without taking a request");

  a_rsp_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid |-> !(rsp_ch.bit_is_set && rsp_ch.found_any))
    else $error("test and find results both set");
`endif

endmodule
`default_nettype wire

// ----- test/bve_reply_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bve_reply_checker
// Watches the request and response channels of the bit vector engine. It keeps
// a shadow copy of the vector, works out the reply to each accepted request,
// and compares every accepted response field by field with the oldest reply
// still owed.
// ---------------------------------------------------------------------------
module bve_reply_checker
  import bve_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bve_req_if   req,
  bve_rsp_if   rsp,
  output int   mismatch_count,
  output int   pending_count
);

  typedef struct packed {
    logic             bit_is_set;
    logic             found_any;
    logic [FSI_W-1:0] first_set_index;
    chunk_t           chunk_value;
  } reply_t;

  vec_t   shadow_bits;
  reply_t owed_replies[$];
  int     reply_number;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns, response %0d: %s", $time, reply_number, what);
    mismatch_count++;
  endtask

  // Applies one request to the shadow vector and returns the reply it causes.
  function automatic reply_t apply_request(input logic [OP_W-1:0] op,
                                           input logic signed [FIELD_W-1:0] bidx,
                                           input logic signed [FIELD_W-1:0] sh,
                                           input logic [CHUNK_IDX_W-1:0] cidx,
                                           input chunk_t data);
    reply_t reply;
    int     idx;
    int     shift_dist;
    reply      = '0;
    idx        = bidx;
    shift_dist = sh;
    case (op)
      OP_CLEAR_ALL: shadow_bits = '0;
      OP_SET: begin
        if (idx >= 0 && idx < MASK_BITS) shadow_bits[idx] = 1'b1;
      end
      OP_CLEAR: begin
        if (idx >= 0 && idx < MASK_BITS) shadow_bits[idx] = 1'b0;
      end
      OP_TEST: begin
        if (idx >= 0 && idx < MASK_BITS) reply.bit_is_set = shadow_bits[idx];
      end
      OP_FIND: begin
        // Scanning downward leaves the lowest set index behind.
        for (int b = MASK_BITS - 1; b >= 0; b--) begin
          if (shadow_bits[b]) begin
            reply.found_any       = 1'b1;
            reply.first_set_index = FSI_W'(b);
          end
        end
      end
      OP_AND: begin
        shadow_bits[cidx*CHUNK_BITS +: CHUNK_BITS] =
          shadow_bits[cidx*CHUNK_BITS +: CHUNK_BITS] & data;
      end
      OP_OR: begin
        shadow_bits[cidx*CHUNK_BITS +: CHUNK_BITS] =
          shadow_bits[cidx*CHUNK_BITS +: CHUNK_BITS] | data;
      end
      OP_SHIFT: begin
        // Distances beyond the vector width empty it, as bits drop off the end.
        if (shift_dist >= 0) shadow_bits = shadow_bits << shift_dist;
        else shadow_bits = shadow_bits >> (-shift_dist);
      end
      OP_READ: reply.chunk_value = shadow_bits[cidx*CHUNK_BITS +: CHUNK_BITS];
      default: ;
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t owed;
    if (rst) begin
      shadow_bits = '0;
      owed_replies.delete();
      reply_number = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.bit_is_set, rsp.found_any, rsp.first_set_index, rsp.chunk_value};
        if (owed_replies.size() == 0) begin
          report_mismatch("response arrived with no request outstanding");
        end else begin
          owed = owed_replies.pop_front();
          if (got.bit_is_set !== owed.bit_is_set)
            report_mismatch($sformatf("bit_is_set got %0b, expected %0b",
                                      got.bit_is_set, owed.bit_is_set));
          if (got.found_any !== owed.found_any)
            report_mismatch($sformatf("found_any got %0b, expected %0b",
                                      got.found_any, owed.found_any));
          if (got.first_set_index !== owed.first_set_index)
            report_mismatch($sformatf("first_set_index got %0d, expected %0d",
                                      got.first_set_index, owed.first_set_index));
          if (got.chunk_value !== owed.chunk_value)
            report_mismatch($sformatf("chunk_value got %h, expected %h",
                                      got.chunk_value, owed.chunk_value));
        end
        reply_number++;
      end
      if (req.valid && req.ready)
        owed_replies.push_back(apply_request(req.operation, req.bit_index,
                                             req.shift_amount, req.chunk_index,
                                             req.chunk_data));
    end
    pending_count = owed_replies.size();
  end

endmodule

// ----- test/tb_bit_vector_engine.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bit_vector_engine
// Drives directed and random requests into the bit vector engine under several
// idle and stall patterns, and gives the verdict from the reply checker.
// ---------------------------------------------------------------------------
module tb_bit_vector_engine;
  import bve_pkg::*;

  localparam int RANDOM_PER_PHASE = 375;
  localparam int DRAIN_CYCLES     = 20;
  localparam int LIMIT_CYCLES     = 200_000;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;
  int   mismatch_count;
  int   pending_count;

  bve_req_if req_ch();
  bve_rsp_if rsp_ch();

  bit_vector_engine DUT (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  bve_reply_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [FIELD_W-1:0] bidx,
                              input logic signed [FIELD_W-1:0] sh,
                              input logic [CHUNK_IDX_W-1:0] cidx,
                              input chunk_t data);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.bit_index    <= bidx;
    req_ch.shift_amount <= sh;
    req_ch.chunk_index  <= cidx;
    req_ch.chunk_data   <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_request();
    int                          pick;
    logic [OP_W-1:0]             op;
    logic signed [FIELD_W-1:0]   bidx;
    logic signed [FIELD_W-1:0]   sh;
    chunk_t                      data;
    pick = $urandom_range(99);
    if (pick < 26) op = OP_SET;
    else if (pick < 36) op = OP_CLEAR;
    else if (pick < 51) op = OP_TEST;
    else if (pick < 63) op = OP_FIND;
    else if (pick < 69) op = OP_AND;
    else if (pick < 77) op = OP_OR;
    else if (pick < 85) op = OP_SHIFT;
    else if (pick < 95) op = OP_READ;
    else if (pick < 97) op = OP_CLEAR_ALL;
    else op = OP_W'(OP_READ + $urandom_range(1, (1 << OP_W) - 1 - OP_READ));
    // Most indexes land inside the vector; the rest cover negative and high ones.
    if ($urandom_range(99) < 75) bidx = FIELD_W'($urandom_range(MASK_BITS - 1));
    else bidx = FIELD_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) sh = FIELD_W'(int'($urandom_range(64)) - 32);
    else if (pick < 85) sh = FIELD_W'(int'($urandom_range(2 * MASK_BITS)) - MASK_BITS);
    else sh = FIELD_W'($urandom);
    // A dense AND operand keeps the vector from emptying too quickly.
    data = (op == OP_AND) ? ($urandom | $urandom) : $urandom;
    send_request(op, bidx, sh, CHUNK_IDX_W'($urandom), data);
  endtask

  initial begin
    rst                 <= 1'b1;
    send_idle_pct        = 0;
    recv_stall_pct      <= 0;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_CLEAR_ALL;
    req_ch.bit_index    <= '0;
    req_ch.shift_amount <= '0;
    req_ch.chunk_index  <= '0;
    req_ch.chunk_data   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: index extremes, out-of-range indexes, every operation,
    // large shifts both ways and the unused operation codes.
    send_request(OP_FIND,      0,    0, 0, '0);
    send_request(OP_SET,       0,    0, 0, '0);
    send_request(OP_SET,       255,  0, 0, '0);
    send_request(OP_SET,       -1,   0, 0, '0);
    send_request(OP_SET,       256,  0, 0, '0);
    send_request(OP_SET,       -512, 0, 0, '0);
    send_request(OP_SET,       511,  0, 0, '0);
    send_request(OP_TEST,      0,    0, 0, '0);
    send_request(OP_TEST,      255,  0, 0, '0);
    send_request(OP_TEST,      -1,   0, 0, '0);
    send_request(OP_TEST,      511,  0, 0, '0);
    send_request(OP_FIND,      0,    0, 0, '0);
    send_request(OP_CLEAR,     0,    0, 0, '0);
    send_request(OP_CLEAR,     -512, 0, 0, '0);
    send_request(OP_FIND,      0,    0, 0, '0);
    send_request(OP_READ,      0,    0, 7, '0);
    send_request(OP_OR,        0,    0, 3, 32'hFFFF_FFFF);
    send_request(OP_AND,       0,    0, 3, 32'h0F0F_0F0F);
    send_request(OP_READ,      0,    0, 3, '0);
    send_request(OP_SHIFT,     0,    1, 0, '0);
    send_request(OP_FIND,      0,    0, 0, '0);
    send_request(OP_SHIFT,     0,  -97, 0, '0);
    send_request(OP_READ,      0,    0, 0, '0);
    send_request(OP_SHIFT,     0,  511, 0, '0);
    send_request(OP_OR,        0,    0, 7, 32'hFFFF_FFFF);
    send_request(OP_SHIFT,     0, -512, 0, '0);
    send_request(OP_OR,        0,    0, 0, 32'h8000_0001);
    send_request(OP_W'(OP_READ + 1), 3, 5, 0, 32'hFFFF_FFFF);
    send_request(OP_W'((1 << OP_W) - 1), 3, 5, 0, 32'hFFFF_FFFF);
    send_request(OP_CLEAR_ALL, 0,    0, 0, '0);
    send_request(OP_READ,      0,    0, 0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 45; end
        default: begin send_idle_pct = 7; recv_stall_pct <= 7; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_request();
    end
    req_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
